@@ rtl/core/dual_stack_shared_buffer_assert.svh @@
// ----------------------------------------------------------------------------
// dual stack shared buffer assertion macros
// concurrent assertion helpers clocked on a rising edge with active low reset
// ----------------------------------------------------------------------------
`ifndef DUAL_STACK_SHARED_BUFFER_ASSERT_SVH
`define DUAL_STACK_SHARED_BUFFER_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define DSB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define DSB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/dsb_pkg.sv @@
// ----------------------------------------------------------------------------
// dual stack shared buffer package
// sizes, operation and status codes, controller commands
// ----------------------------------------------------------------------------
`default_nettype none

package dsb_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CNT_W:0]    sum_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    MODE_PUSH_ONE = 2'd0,
    MODE_PUSH_TWO = 2'd1,
    MODE_POP_ONE  = 2'd2,
    MODE_POP_TWO  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic show;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/dsb_ram.sv @@
// ----------------------------------------------------------------------------
// dsb generic ram
// single port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module dsb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/dsb_ctrl.sv @@
// ----------------------------------------------------------------------------
// dsb controller
// sequences one operation through capture, execute and result cycles
// ----------------------------------------------------------------------------
`default_nettype none

module dsb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  output logic               done_o,
  output dsb_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC:  state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o     = (state_q != S_IDLE);
  assign done_o     = (state_q == S_DONE);
  assign cmd_o.load = (state_q == S_IDLE) && start_i;
  assign cmd_o.exec = (state_q == S_EXEC);
  assign cmd_o.show = (state_q == S_DONE);

endmodule

`default_nettype wire

@@ rtl/core/dsb_dp.sv @@
// ----------------------------------------------------------------------------
// dsb datapath
// stack counts, store addressing and result formatting
// ----------------------------------------------------------------------------
`default_nettype none

module dsb_dp (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dsb_pkg::cmd_t        cmd_i,
  input  wire logic [1:0]           mode_i,
  input  wire logic signed [31:0]   push_word_i,
  output logic signed [31:0]        pop_word_o,
  output logic [1:0]                status_o
);

  dsb_pkg::mode_e   mode_q;
  dsb_pkg::word_t   word_q;
  dsb_pkg::cnt_t    lower_q, lower_d;
  dsb_pkg::cnt_t    upper_q, upper_d;
  dsb_pkg::status_e status_q, status_d;
  dsb_pkg::sum_t    fill;
  dsb_pkg::cnt_t    top_idx;
  dsb_pkg::addr_t   addr;
  dsb_pkg::word_t   rdata;
  logic             room;
  logic             we;
  logic             re;

  assign fill = dsb_pkg::sum_t'(lower_q) + dsb_pkg::sum_t'(upper_q);
  assign room = (fill < dsb_pkg::sum_t'(dsb_pkg::DEPTH));

  always_comb begin
    lower_d  = lower_q;
    upper_d  = upper_q;
    status_d = dsb_pkg::ST_OK;
    top_idx  = lower_q;
    we       = 1'b0;
    re       = 1'b0;
    unique case (mode_q)
      dsb_pkg::MODE_PUSH_ONE: begin
        top_idx = lower_q;
        if (room) begin
          we      = cmd_i.exec;
          lower_d = lower_q + dsb_pkg::cnt_t'(1);
        end else begin
          status_d = dsb_pkg::ST_FULL;
        end
      end
      dsb_pkg::MODE_PUSH_TWO: begin
        top_idx = dsb_pkg::cnt_t'(dsb_pkg::DEPTH - 1) - upper_q;
        if (room) begin
          we      = cmd_i.exec;
          upper_d = upper_q + dsb_pkg::cnt_t'(1);
        end else begin
          status_d = dsb_pkg::ST_FULL;
        end
      end
      dsb_pkg::MODE_POP_ONE: begin
        top_idx = lower_q - dsb_pkg::cnt_t'(1);
        if (lower_q != '0) begin
          re      = cmd_i.exec;
          lower_d = lower_q - dsb_pkg::cnt_t'(1);
        end else begin
          status_d = dsb_pkg::ST_EMPTY;
        end
      end
      dsb_pkg::MODE_POP_TWO: begin
        top_idx = dsb_pkg::cnt_t'(dsb_pkg::DEPTH) - upper_q;
        if (upper_q != '0) begin
          re      = cmd_i.exec;
          upper_d = upper_q - dsb_pkg::cnt_t'(1);
        end else begin
          status_d = dsb_pkg::ST_EMPTY;
        end
      end
      default: begin
        status_d = dsb_pkg::ST_OK;
      end
    endcase
  end

  assign addr = top_idx[dsb_pkg::ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= dsb_pkg::mode_e'(mode_i);
      word_q <= push_word_i;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= '0;
      upper_q <= '0;
    end else if (cmd_i.exec) begin
      lower_q <= lower_d;
      upper_q <= upper_d;
    end
  end

  dsb_ram #(
    .Width (dsb_pkg::WORD_W),
    .Depth (dsb_pkg::DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .re_i    (re),
    .addr_i  (addr),
    .wdata_i (word_q),
    .rdata_o (rdata)
  );

  // pushes return zero, empty pops all ones
  always_comb begin
    pop_word_o = '0;
    if (cmd_i.show) begin
      if (status_q == dsb_pkg::ST_EMPTY) begin
        pop_word_o = '1;
      end else if (mode_q == dsb_pkg::MODE_POP_ONE || mode_q == dsb_pkg::MODE_POP_TWO) begin
        pop_word_o = rdata;
      end
    end
  end

  assign status_o = cmd_i.show ? status_q : dsb_pkg::ST_OK;

endmodule

`default_nettype wire

@@ rtl/core/dual_stack_shared_buffer.sv @@
// ----------------------------------------------------------------------------
// dual stack shared buffer
// two lifo stacks in one store, stack one from the bottom, stack two from
// the top
//
//   channel   handshake          payload
//   command   start_i / busy_o   mode_i, push_word_i
//   result    done_o strobe      pop_word_o, status_o
//
// a word accepted at an edge passes through the execute and done states and its
// result is shown on done_o in the done state; busy_o stays high in both, so
// the next word waits, due to the input capture and the registered store read
// reset clears both stack counts; the store itself holds no reset
// the result is shown for one cycle and cannot be held off
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_stack_shared_buffer_assert.svh"

module dual_stack_shared_buffer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [1:0]         mode_i,
  input  wire logic signed [31:0] push_word_i,
  output logic                    done_o,
  output logic signed [31:0]      pop_word_o,
  output logic [1:0]              status_o
);

  dsb_pkg::cmd_t cmd;
  logic          empty_shown;

  dsb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  dsb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .mode_i      (mode_i),
    .push_word_i (push_word_i),
    .pop_word_o  (pop_word_o),
    .status_o    (status_o)
  );

  assign empty_shown = done_o && (status_o == dsb_pkg::ST_EMPTY);

  `DSB_ASSERT(a_accept_then_result, clk_i, rst_ni, (start_i && !busy_o) |=> ##1 done_o, "no done")
  `DSB_ASSERT(a_strobe_single, clk_i, rst_ni, done_o |=> !done_o, "strobe too long")
  `DSB_ASSERT_IMP(a_empty_word, clk_i, rst_ni, empty_shown, pop_word_o == '1, "bad empty word")

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// dual stack shared buffer testbench
// drives push and pop words through the start/busy handshake with random
// gaps, keeps a shadow of both stacks to predict each popped word and status,
// and checks every done strobe against the oldest prediction in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import dsb_pkg::*;

  localparam int unsigned RAND_ITEMS = 1650;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    mode_e       mode;
    word_t       word;
    int unsigned gap;
  } stack_cmd_t;

  typedef struct {
    word_t   word;
    status_e status;
  } reply_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         mode_i = MODE_PUSH_ONE;
  logic signed [31:0] push_word_i = '0;
  logic               done_o;
  logic signed [31:0] pop_word_o;
  logic [1:0]         status_o;

  stack_cmd_t  cmd_queue[$];
  reply_t      due_replies[$];
  stack_cmd_t  drv_cmd;
  reply_t      want;
  word_t       shadow_mem [DEPTH];
  int unsigned lo_fill = 0;
  int unsigned hi_fill = 0;
  int unsigned idle_left = 0;
  int unsigned cmd_total = 0;
  int unsigned accepted_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;

  dual_stack_shared_buffer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .mode_i      (mode_i),
    .push_word_i (push_word_i),
    .done_o      (done_o),
    .pop_word_o  (pop_word_o),
    .status_o    (status_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // shadow of both stacks, one operation per accepted word
  function automatic reply_t apply_stack_op(mode_e m, word_t w);
    reply_t r;
    logic   room;
    r.word = '0;
    r.status = ST_OK;
    room = (lo_fill + hi_fill) < DEPTH;
    case (m)
      MODE_PUSH_ONE: begin
        if (room) begin
          shadow_mem[lo_fill] = w;
          lo_fill++;
        end else begin
          r.status = ST_FULL;
        end
      end
      MODE_PUSH_TWO: begin
        if (room) begin
          shadow_mem[DEPTH - 1 - hi_fill] = w;
          hi_fill++;
        end else begin
          r.status = ST_FULL;
        end
      end
      MODE_POP_ONE: begin
        if (lo_fill != 0) begin
          lo_fill--;
          r.word = shadow_mem[lo_fill];
        end else begin
          r.word = '1;
          r.status = ST_EMPTY;
        end
      end
      default: begin
        if (hi_fill != 0) begin
          hi_fill--;
          r.word = shadow_mem[DEPTH - 1 - hi_fill];
        end else begin
          r.word = '1;
          r.status = ST_EMPTY;
        end
      end
    endcase
    return r;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned rand_gap(bit quiet);
    int unsigned pick;
    if (quiet) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_cmd(mode_e m, word_t w, int unsigned g);
    stack_cmd_t c;
    c.mode = m;
    c.word = w;
    c.gap = g;
    cmd_queue.push_back(c);
    cmd_total++;
  endtask

  task automatic log_fail(string msg);
    if (fail_cnt < 10) $display("%s", msg);
    fail_cnt++;
  endtask

  // driver: gap is counted after the word is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      mode_i <= MODE_PUSH_ONE;
      push_word_i <= '0;
      idle_left <= 0;
    end else if (!(start_i && busy_o)) begin
      if (idle_left != 0) begin
        idle_left <= idle_left - 1;
        start_i <= 1'b0;
      end else if (cmd_queue.size() != 0) begin
        drv_cmd = cmd_queue.pop_front();
        start_i <= 1'b1;
        mode_i <= drv_cmd.mode;
        push_word_i <= drv_cmd.word;
        idle_left <= drv_cmd.gap;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: check the strobe first, then predict the word taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (due_replies.size() == 0) begin
          log_fail($sformatf("unexpected result: pop word %h status %0d",
                             pop_word_o, status_o));
        end else begin
          want = due_replies.pop_front();
          if (pop_word_o !== want.word || status_o !== want.status) begin
            log_fail($sformatf("mismatch: pop word exp %h got %h, status exp %0d got %0d",
                               want.word, pop_word_o, want.status, status_o));
          end
        end
      end
      if (start_i && !busy_o) begin
        due_replies.push_back(apply_stack_op(mode_e'(mode_i), push_word_i));
        accepted_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned burst;
    int unsigned push_pct;
    int unsigned lean;
    int unsigned side;
    bit          quiet;
    mode_e       m;

    // empty pops, extremes on both stacks, then fill to full and overflow
    add_cmd(MODE_POP_ONE, '0, rand_gap(0));
    add_cmd(MODE_POP_TWO, '1, rand_gap(0));
    add_cmd(MODE_PUSH_ONE, 32'h7FFF_FFFF, rand_gap(0));
    add_cmd(MODE_PUSH_TWO, 32'h8000_0000, rand_gap(0));
    add_cmd(MODE_POP_TWO, $urandom, rand_gap(0));
    add_cmd(MODE_POP_ONE, $urandom, rand_gap(0));
    for (int i = 0; i < DEPTH; i++) begin
      add_cmd(i[0] ? MODE_PUSH_TWO : MODE_PUSH_ONE, rand_word(), rand_gap(0));
    end
    add_cmd(MODE_PUSH_ONE, '1, rand_gap(0));
    add_cmd(MODE_PUSH_TWO, '0, rand_gap(0));

    // random bursts leaning to push or pop and to one stack
    while (cmd_total < RAND_ITEMS) begin
      burst = $urandom_range(8, 40);
      case ($urandom_range(0, 2))
        0: push_pct = 80;
        1: push_pct = 20;
        default: push_pct = 50;
      endcase
      lean = $urandom_range(0, 2);
      quiet = ($urandom_range(0, 3) == 0);
      repeat (burst) begin
        side = (lean == 2) ? $urandom_range(0, 1) : lean;
        if ($urandom_range(0, 99) < push_pct) m = side ? MODE_PUSH_TWO : MODE_PUSH_ONE;
        else m = side ? MODE_POP_TWO : MODE_POP_ONE;
        add_cmd(m, rand_word(), rand_gap(quiet));
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cnt < cmd_total) @(posedge clk_i);
    while (due_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (fail_cnt == 0 && due_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
